// ===== rtl/core/mpt_pkg.sv =====
// shared types and constants of the max priority table
`default_nettype none

package mpt_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int PAY_W       = 32;
    localparam int PRI_W       = 16;
    localparam int OP_W        = 3;
    localparam int ST_W        = 3;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
    localparam logic [PRI_W-1:0] PRI_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_PROMOTE = 3'd1,
        OP_POP     = 3'd2,
        OP_PEEK    = 3'd3,
        OP_CHECK   = 3'd4,
        OP_READ    = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_NEVER   = 3'd3,
        ST_REMOVED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOOK,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic             live;
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [IDX_W-1:0] entry_id;
        logic [PAY_W-1:0] payload;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] result_id;
        logic [PAY_W-1:0] result_payload;
        logic [PRI_W-1:0] result_priority;
        logic             is_live;
    } t_res;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== rtl/core/mpt_if.sv =====
// request and response channel interfaces of the max priority table
`default_nettype none

interface mpt_in_if;
    logic                        valid;
    logic                        ready;
    logic [mpt_pkg::OP_W-1:0]    opcode;
    logic [mpt_pkg::IDX_W-1:0]   entry_id;
    logic [mpt_pkg::PAY_W-1:0]   payload;

    modport source (output valid, output opcode, output entry_id, output payload, input ready);
    modport sink   (input valid, input opcode, input entry_id, input payload, output ready);
endinterface

interface mpt_out_if;
    logic                        valid;
    logic                        ready;
    logic [mpt_pkg::ST_W-1:0]    status;
    logic [mpt_pkg::IDX_W-1:0]   result_id;
    logic [mpt_pkg::PAY_W-1:0]   result_payload;
    logic [mpt_pkg::PRI_W-1:0]   result_priority;
    logic                        is_live;

    modport source (output valid, output status, output result_id, output result_payload,
                    output result_priority, output is_live, input ready);
    modport sink   (input valid, input status, input result_id, input result_payload,
                    input result_priority, input is_live, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mpt_mem.sv =====
// entry memory: live flag, priority and payload, one write and one registered read
`default_nettype none

module mpt_mem (
    input  wire logic              i_clk,
    input  wire mpt_pkg::t_mem_req i_req,
    output mpt_pkg::t_entry        o_rd_data
);
    import mpt_pkg::*;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/mpt_ctrl.sv =====
// sequencer with the shared priority compare that scans the entry memory
`default_nettype none

module mpt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire mpt_pkg::t_item    i_item,
    output mpt_pkg::t_mem_req      o_mem_req,
    input  wire mpt_pkg::t_entry   i_rd_data,
    output mpt_pkg::t_res          o_res,
    output logic                   o_res_valid,
    input  wire logic              i_res_ack
);
    import mpt_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_op              r_op, n_op;
    logic [IDX_W-1:0] r_id, n_id;
    logic [PAY_W-1:0] r_pl, n_pl;
    logic [IDX_W-1:0] r_scan_idx, n_scan_idx;
    logic             r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_best_idx, n_best_idx;
    logic [PRI_W-1:0] r_best_pri, n_best_pri;
    logic [PAY_W-1:0] r_best_pl, n_best_pl;
    t_res             r_res, n_res;
    logic             take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_id       <= n_id;
        r_pl       <= n_pl;
        r_scan_idx <= n_scan_idx;
        r_rd_idx   <= n_rd_idx;
        r_best_idx <= n_best_idx;
        r_best_pri <= n_best_pri;
        r_best_pl  <= n_best_pl;
        r_res      <= n_res;
    end

    // shared compare: later ids win ties
    assign take = r_rd_vld && i_rd_data.live && (!r_found || (i_rd_data.pri >= r_best_pri));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_id        = r_id;
        n_pl        = r_pl;
        n_scan_idx  = r_scan_idx;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_pri  = r_best_pri;
        n_best_pl   = r_best_pl;
        n_res       = r_res;
        o_mem_req   = '0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        if (take) begin
            n_found    = 1'b1;
            n_best_idx = r_rd_idx;
            n_best_pri = i_rd_data.pri;
            n_best_pl  = i_rd_data.payload;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op    = t_op'(i_item.opcode);
                    n_id    = i_item.entry_id;
                    n_pl    = i_item.payload;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_FIN;
                unique case (r_op)
                    OP_ADD: begin
                        if (r_count == MAX_CNT) begin
                            n_res.status = ST_FULL;
                        end else begin
                            o_mem_req.wr_en           = 1'b1;
                            o_mem_req.wr_addr         = r_count[IDX_W-1:0];
                            o_mem_req.wr_data.live    = 1'b1;
                            o_mem_req.wr_data.pri     = '0;
                            o_mem_req.wr_data.payload = r_pl;
                            n_res.result_id           = r_count[IDX_W-1:0];
                            n_count                   = r_count + CNT_W'(1);
                        end
                    end
                    OP_PROMOTE, OP_CHECK, OP_READ: begin
                        if (CNT_W'(r_id) >= r_count) begin
                            n_res.status = ST_NEVER;
                        end else begin
                            o_mem_req.rd_en   = 1'b1;
                            o_mem_req.rd_addr = r_id;
                            n_state           = S_LOOK;
                        end
                    end
                    OP_POP, OP_PEEK: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_found    = 1'b0;
                            n_scan_idx = '0;
                            n_state    = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_LOOK: begin
                n_state = S_FIN;
                priority if (!i_rd_data.live) begin
                    n_res.status = ST_REMOVED;
                end else if (r_op == OP_PROMOTE) begin
                    if (i_rd_data.pri != PRI_MAX) begin
                        o_mem_req.wr_en       = 1'b1;
                        o_mem_req.wr_addr     = r_id;
                        o_mem_req.wr_data     = i_rd_data;
                        o_mem_req.wr_data.pri = i_rd_data.pri + PRI_W'(1);
                    end
                end else if (r_op == OP_CHECK) begin
                    n_res.is_live = 1'b1;
                end else begin
                    n_res.result_payload = i_rd_data.payload;
                end
            end
            S_SCAN: begin
                o_mem_req.rd_en   = 1'b1;
                o_mem_req.rd_addr = r_scan_idx;
                n_rd_vld          = 1'b1;
                n_rd_idx          = r_scan_idx;
                if (CNT_W'(r_scan_idx) == (r_count - CNT_W'(1))) begin
                    n_state = S_DRAIN;
                end else begin
                    n_scan_idx = r_scan_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                // last read word is compared here
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = S_FIN;
                if (!r_found) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_res.result_id       = r_best_idx;
                    n_res.result_payload  = r_best_pl;
                    n_res.result_priority = r_best_pri;
                    if (r_op == OP_POP) begin
                        o_mem_req.wr_en           = 1'b1;
                        o_mem_req.wr_addr         = r_best_idx;
                        o_mem_req.wr_data.live    = 1'b0;
                        o_mem_req.wr_data.pri     = r_best_pri;
                        o_mem_req.wr_data.payload = r_best_pl;
                    end
                end
            end
            S_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/max_priority_table_top.sv =====
// Max priority table: up to 1024 entries, each a 32-bit payload with a 16-bit priority.
// Ids are handed out in add order and never reused. One request is handled at a time:
// add goes through the exec and finish states, promote, check and read add a lookup
// state (not for an id never added), and pop and peek scan, drain and commit (not before
// the first add), since the maximum is found by reading every added entry once through
// the single read port of the entry memory and comparing it in one shared comparator.
// The result sits in an output register, so the next request is taken while it waits.
// No clearing pass runs after reset: an add counter bounds which entries are ever read.
`default_nettype none

module max_priority_table_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mpt_in_if.sink     i_in,
    mpt_out_if.source  o_out
);
    import mpt_pkg::*;

    t_item    item;
    t_mem_req mem_req;
    t_entry   rd_data;
    t_res     res;
    logic     res_valid;
    logic     res_ack;
    logic     in_ready;
    logic     r_out_valid;
    t_res     r_out;

    assign item.opcode   = i_in.opcode;
    assign item.entry_id = i_in.entry_id;
    assign item.payload  = i_in.payload;

    mpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_item      (item),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ack   (res_ack)
    );

    mpt_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign i_in.ready = in_ready;
    assign res_ack    = res_valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ack) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ack) begin
            r_out <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.result_id       = r_out.result_id;
    assign o_out.result_payload  = r_out.result_payload;
    assign o_out.result_priority = r_out.result_priority;
    assign o_out.is_live         = r_out.is_live;

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while a request is in progress");

    a_live_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_live) |-> (r_out.status == ST_OK))
        else $error("live answer with a failing status");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_FULL)) |->
        ((r_out.result_id == '0) && (r_out.result_payload == '0)))
        else $error("full status with nonzero fields");

    a_ack_one_shot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_ack |=> !res_valid)
        else $error("result handed over twice");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_max_priority_table_top.sv =====
// testbench for the max priority table: queued requests, shadow table, field-by-field checks
`default_nettype none

module tb_max_priority_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mpt_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int RANDOM_PER_PHASE = 130;
    localparam int HOLD_CYCLES      = 400;
    localparam int TAIL_CYCLES      = MAX_ENTRIES + 64;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mpt_in_if  in_ch ();
    mpt_out_if out_ch ();

    max_priority_table_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the table contents
    logic [PAY_W-1:0] tbl_payload  [MAX_ENTRIES];
    logic [PRI_W-1:0] tbl_priority [MAX_ENTRIES];
    bit               tbl_live     [MAX_ENTRIES];
    int               tbl_count = 0;

    t_item requests_q [$];
    t_res  answers_due [$];
    t_item next_req;
    t_res  want_res;

    int mismatches = 0;
    int gen_adds;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    bit hold_go = 1'b0;
    bit hold_used;

    function automatic t_status id_state(logic [IDX_W-1:0] id);
        if (id >= tbl_count)
            return ST_NEVER;
        return tbl_live[id] ? ST_OK : ST_REMOVED;
    endfunction

    function automatic t_res answer_of(logic [OP_W-1:0] op, logic [IDX_W-1:0] id,
                                       logic [PAY_W-1:0] pl);
        t_res r;
        bit   found;
        int   best;
        r     = '0;
        found = 1'b0;
        best  = 0;
        case (op)
            OP_ADD: begin
                if (tbl_count >= MAX_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_payload[tbl_count]  = pl;
                    tbl_priority[tbl_count] = '0;
                    tbl_live[tbl_count]     = 1'b1;
                    r.result_id             = IDX_W'(tbl_count);
                    tbl_count++;
                end
            end
            OP_PROMOTE: begin
                r.status = id_state(id);
                if (r.status == ST_OK && tbl_priority[id] != PRI_MAX)
                    tbl_priority[id] = tbl_priority[id] + 1'b1;
            end
            OP_POP, OP_PEEK: begin
                // ties go to the later id, hence >=
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_live[i] && (!found || tbl_priority[i] >= tbl_priority[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.result_id       = IDX_W'(best);
                    r.result_payload  = tbl_payload[best];
                    r.result_priority = tbl_priority[best];
                    if (op == OP_POP)
                        tbl_live[best] = 1'b0;
                end
            end
            OP_CHECK: begin
                r.status  = id_state(id);
                r.is_live = (r.status == ST_OK);
            end
            OP_READ: begin
                r.status = id_state(id);
                if (r.status == ST_OK)
                    r.result_payload = tbl_payload[id];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [PAY_W-1:0] got, logic [PAY_W-1:0] want);
        $display("mismatch on %s at %0t: got %0h, want %0h", field, $realtime, got, want);
        mismatches++;
    endtask

    task automatic push_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] id, logic [PAY_W-1:0] pl);
        t_item it;
        it.opcode   = op;
        it.entry_id = id;
        it.payload  = pl;
        requests_q = {requests_q, it};
        if (op == OP_ADD && gen_adds < MAX_ENTRIES)
            gen_adds++;
    endtask

    // mostly ids that were handed out, so promotes and reads hit real entries
    task automatic push_random(output bit counted);
        int unsigned      pick;
        logic [IDX_W-1:0] id;
        logic [PAY_W-1:0] pl;
        pick    = $urandom_range(99);
        pl      = $urandom;
        counted = 1'b1;
        if (gen_adds > 0 && $urandom_range(99) < 85)
            id = IDX_W'($urandom_range(gen_adds - 1));
        else
            id = IDX_W'($urandom);
        if (pick < 35)
            push_item(OP_ADD, id, pl);
        else if (pick < 60)
            push_item(OP_PROMOTE, id, pl);
        else if (pick < 70)
            push_item(OP_POP, id, pl);
        else if (pick < 78)
            push_item(OP_PEEK, id, pl);
        else if (pick < 86)
            push_item(OP_CHECK, id, pl);
        else if (pick < 94)
            push_item(OP_READ, id, pl);
        else begin
            push_item((pick < 97) ? OP_SPARE_LO : OP_SPARE_HI, id, pl);
            counted = 1'b0;
        end
    endtask

    task automatic random_burst(int n);
        int  done_cnt;
        bit  counted;
        done_cnt = 0;
        while (done_cnt < n) begin
            push_random(counted);
            if (counted)
                done_cnt++;
        end
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (requests_q.size() != 0 || in_ch.valid || answers_due.size() != 0)
            @(negedge i_clk);
    endtask

    // request side: one transfer offered at a time, held until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid    <= 1'b0;
            in_ch.opcode   <= OP_ADD;
            in_ch.entry_id <= '0;
            in_ch.payload  <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                answers_due = {answers_due,
                               answer_of(in_ch.opcode, in_ch.entry_id, in_ch.payload)};
            if (!in_ch.valid || in_ch.ready) begin
                if (requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req        = requests_q.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.opcode   <= next_req.opcode;
                    in_ch.entry_id <= next_req.entry_id;
                    in_ch.payload  <= next_req.payload;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected result", PAY_W'(out_ch.status), '0);
                end else begin
                    want_res = answers_due.pop_front();
                    if (out_ch.status !== want_res.status)
                        report_mismatch("status", PAY_W'(out_ch.status),
                                        PAY_W'(want_res.status));
                    if (out_ch.result_id !== want_res.result_id)
                        report_mismatch("result_id", PAY_W'(out_ch.result_id),
                                        PAY_W'(want_res.result_id));
                    if (out_ch.result_payload !== want_res.result_payload)
                        report_mismatch("result_payload", out_ch.result_payload,
                                        want_res.result_payload);
                    if (out_ch.result_priority !== want_res.result_priority)
                        report_mismatch("result_priority", PAY_W'(out_ch.result_priority),
                                        PAY_W'(want_res.result_priority));
                    if (out_ch.is_live !== want_res.is_live)
                        report_mismatch("is_live", PAY_W'(out_ch.is_live),
                                        PAY_W'(want_res.is_live));
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, started once on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_go && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        gen_adds       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, unknown ids, ties, removal, spare opcodes
        push_item(OP_PEEK, '0, '0);
        push_item(OP_POP, '0, '0);
        push_item(OP_PROMOTE, '0, '0);
        push_item(OP_CHECK, '1, '0);
        push_item(OP_READ, '0, '0);
        push_item(OP_ADD, '1, '0);
        push_item(OP_ADD, '0, '1);
        push_item(OP_ADD, '0, 32'h5a5a_5a5a);
        push_item(OP_PEEK, '0, '0);
        push_item(OP_PROMOTE, 10'd0, '0);
        push_item(OP_PROMOTE, 10'd0, '0);
        push_item(OP_PROMOTE, 10'd1, '0);
        push_item(OP_PEEK, '0, '0);
        push_item(OP_CHECK, 10'd1, '0);
        push_item(OP_READ, 10'd1, '0);
        push_item(OP_POP, '0, '0);
        push_item(OP_CHECK, 10'd0, '0);
        push_item(OP_PROMOTE, 10'd0, '0);
        push_item(OP_READ, 10'd0, '0);
        push_item(OP_SPARE_LO, '1, '1);
        push_item(OP_SPARE_HI, '0, '0);
        push_item(OP_POP, '0, '0);
        push_item(OP_POP, '0, '0);
        push_item(OP_POP, '0, '0);
        push_item(OP_READ, '1, '0);
        wait_drained();

        // random phases; the first opens with the receiver held off
        set_idling(0, 0);
        hold_go = 1'b1;
        random_burst(RANDOM_PER_PHASE);
        wait_drained();
        set_idling(50, 0);
        random_burst(RANDOM_PER_PHASE);
        wait_drained();
        set_idling(0, 50);
        random_burst(RANDOM_PER_PHASE);
        wait_drained();
        set_idling(27, 27);
        random_burst(RANDOM_PER_PHASE);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/mpt_pkg.sv
rtl/core/mpt_if.sv
rtl/core/mpt_mem.sv
rtl/core/mpt_ctrl.sv
rtl/core/max_priority_table_top.sv
tb/sv/tb_max_priority_table_top.sv
